// ===== hw/rtl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants for the LRU tag cache with pending set.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int STAMP_BITS   = 32;
    localparam int IDX_BITS     = 4;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_FILL   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;      // capture the request beat
        logic scan;      // run one slot and one pending compare step
        logic commit;    // update state and build the result
    } t_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic scan_last; // scan counter is at the last slot
    } t_sts;

endpackage

// ===== hw/rtl/ltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltc_ctrl
// Sequencer: load a request, scan all slots one per cycle, commit, present.
// ----------------------------------------------------------------------------
module ltc_ctrl import ltc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid;

    // input closed while busy and while in reset
    assign o_stall = !i_rst_n || (r_state != S_IDLE);
    assign o_valid = r_valid;

    // command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = i_valid && !o_stall;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT);
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_sts.scan_last) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ltc_dp.sv =====
// ----------------------------------------------------------------------------
// ltc_dp
// Slot and pending-set storage, serial scan, state update and result.
// ----------------------------------------------------------------------------
module ltc_dp import ltc_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [1:0]           i_req_type,
    input  logic [31:0]          i_key,
    input  logic                 i_key_empty,
    input  logic                 i_fill_ok,
    output logic                 o_hit,
    output logic [IDX_BITS-1:0]  o_slot_index,
    output logic                 o_request_issued,
    output logic                 o_evicted,
    output logic                 o_fill_stored
);

    localparam int SB = $clog2(SLOTS);
    localparam int CB = $clog2(SLOTS + 1);
    localparam int KB = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam logic [SB-1:0] LAST = SB'(SLOTS - 1);

    // storage
    logic [STAMP_BITS-1:0] r_stamp [SLOTS];
    logic [KEY_BITS-1:0]   r_tag   [SLOTS];
    logic [KEY_BITS-1:0]   r_ptag  [SLOTS];
    logic [CB-1:0]         r_pcnt;
    logic [STAMP_BITS-1:0] r_clock;

    // request beat
    t_req                  r_type;
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_empty, r_ok;

    // scan results
    logic [SB-1:0]         r_i;
    logic                  r_hit;
    logic [SB-1:0]         r_hidx;
    logic                  r_free;
    logic [SB-1:0]         r_vidx;
    logic [STAMP_BITS-1:0] r_vstamp;
    logic                  r_pfound;
    logic [SB-1:0]         r_pidx;

    // result
    logic                  r_o_hit, r_o_req, r_o_ev, r_o_fs;
    logic [IDX_BITS-1:0]   r_o_idx;

    logic                  s_used, s_pin;
    logic [STAMP_BITS-1:0] s_next;
    logic [CB-1:0]         s_i_ext;

    assign s_used  = (r_stamp[r_i] != '0);
    assign s_i_ext = CB'(r_i);
    assign s_pin   = (s_i_ext < r_pcnt);
    assign s_next  = r_clock + 1'b1;
    assign o_sts.scan_last = (r_i == LAST);

    assign o_hit            = r_o_hit;
    assign o_slot_index     = r_o_idx;
    assign o_request_issued = r_o_req;
    assign o_evicted        = r_o_ev;
    assign o_fill_stored    = r_o_fs;

    // request capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type   <= t_req'(i_req_type);
            r_key    <= KEY_BITS'(i_key[KB-1:0]);
            r_empty  <= i_key_empty;
            r_ok     <= i_fill_ok;
            r_i      <= '0;
            r_hit    <= 1'b0;
            r_hidx   <= '0;
            r_free   <= 1'b0;
            r_vidx   <= '0;
            r_vstamp <= '1;
            r_pfound <= 1'b0;
            r_pidx   <= '0;
        end else if (i_cmd.scan) begin
            if (s_used && r_tag[r_i] == r_key && !r_hit) begin
                r_hit  <= 1'b1;
                r_hidx <= r_i;
            end
            if (!r_free) begin
                if (!s_used) begin
                    r_free   <= 1'b1;
                    r_vidx   <= r_i;
                    r_vstamp <= '0;
                end else if (r_i == '0 || r_stamp[r_i] < r_vstamp) begin
                    r_vidx   <= r_i;
                    r_vstamp <= r_stamp[r_i];
                end
            end
            if (s_pin && r_ptag[r_i] == r_key && !r_pfound) begin
                r_pfound <= 1'b1;
                r_pidx   <= r_i;
            end
            if (r_i != LAST) r_i <= r_i + 1'b1;
        end
    end

    // state update and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS; j++) r_stamp[j] <= '0;
            r_clock <= '0;
            r_pcnt  <= '0;
            r_o_hit <= 1'b0;
            r_o_req <= 1'b0;
            r_o_ev  <= 1'b0;
            r_o_fs  <= 1'b0;
            r_o_idx <= '0;
        end else if (i_cmd.commit) begin
            r_o_hit <= 1'b0;
            r_o_req <= 1'b0;
            r_o_ev  <= 1'b0;
            r_o_fs  <= 1'b0;
            r_o_idx <= '0;
            unique case (r_type)
                REQ_LOOKUP: begin
                    if (!r_empty) begin
                        if (r_hit) begin
                            r_clock         <= s_next;
                            r_stamp[r_hidx] <= s_next;
                            r_o_hit         <= 1'b1;
                            r_o_idx         <= IDX_BITS'(r_hidx);
                        end else if (!r_pfound) begin
                            if (r_pcnt < CB'(SLOTS)) begin
                                r_ptag[r_pcnt[SB-1:0]] <= r_key;
                                r_pcnt <= r_pcnt + 1'b1;
                            end
                            r_o_req <= 1'b1;
                        end
                    end
                end
                REQ_FILL: begin
                    // remove pending entry by shifting the tail down
                    if (r_pfound) begin
                        for (int j = 0; j < SLOTS - 1; j++)
                            if (SB'(j) >= r_pidx) r_ptag[j] <= r_ptag[j + 1];
                        r_pcnt <= r_pcnt - 1'b1;
                    end
                    r_tag[r_vidx] <= r_key;
                    r_o_idx <= IDX_BITS'(r_vidx);
                    r_o_ev  <= !r_free;
                    if (r_ok) begin
                        r_clock         <= s_next;
                        r_stamp[r_vidx] <= s_next;
                        r_o_fs          <= (s_next != '0);
                    end else begin
                        r_stamp[r_vidx] <= '0;
                    end
                end
                REQ_CLEAR: begin
                    for (int j = 0; j < SLOTS; j++) r_stamp[j] <= '0;
                    r_pcnt <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/lru_tag_cache_with_pending_set.sv =====
// ----------------------------------------------------------------------------
// lru_tag_cache_with_pending_set
// Fully associative LRU tag cache with a set of outstanding fetch keys.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// req      in         i_valid / o_stall  i_req_type i_key i_key_empty i_fill_ok
// rsp      out        o_valid / i_stall  o_hit o_slot_index o_request_issued
//                                        o_evicted o_fill_stored
//
// One request at a time: a load step, a serial scan of the slots (one slot and one
// pending entry compared per cycle), a commit step, then the result beat.
// The scan counter walks the slots. A stalled result holds the input stalled.
// Synchronous reset frees all slots, empties the pending set, zeroes the clock.
// ----------------------------------------------------------------------------
module lru_tag_cache_with_pending_set import ltc_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_req_type,
    input  logic [31:0]         i_key,
    input  logic                i_key_empty,
    input  logic                i_fill_ok,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic [IDX_BITS-1:0] o_slot_index,
    output logic                o_request_issued,
    output logic                o_evicted,
    output logic                o_fill_stored
);

    t_cmd s_cmd;
    t_sts s_sts;

    ltc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (s_cmd),
        .i_sts   (s_sts)
    );

    ltc_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .o_sts            (s_sts),
        .i_req_type       (i_req_type),
        .i_key            (i_key),
        .i_key_empty      (i_key_empty),
        .i_fill_ok        (i_fill_ok),
        .o_hit            (o_hit),
        .o_slot_index     (o_slot_index),
        .o_request_issued (o_request_issued),
        .o_evicted        (o_evicted),
        .o_fill_stored    (o_fill_stored)
    );

`ifndef NO_ASSERTIONS
    // a result beat never claims both a hit and a fetch request
    a_hit_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_request_issued))
        else $error("hit and request both set");

    // no input accepted while a result is waiting
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // a stored fill cannot also be a hit
    a_fill_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fill_stored |-> !o_hit)
        else $error("fill reported as hit");
`endif

endmodule

// ===== test/lru_tag_cache_with_pending_set_tb.sv =====
// ----------------------------------------------------------------------------
// lru_tag_cache_with_pending_set_tb
// Drives lookups, fills and clears into the LRU tag cache and checks every
// response beat against a behavioral copy of the cache and its pending set.
// Directed rows and sequences open the run, then random traffic over a small key pool.
// ----------------------------------------------------------------------------
module lru_tag_cache_with_pending_set_tb import ltc_pkg::*;;

    localparam int NSLOT     = 16;
    localparam int WDOG_MAX  = 2000;
    localparam int NRAND     = 1630;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic        key_empty;
        logic        fill_ok;
    } t_req_beat;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot_index;
        logic       request_issued;
        logic       evicted;
        logic       fill_stored;
    } t_rsp_beat;

    // directed row: request plus optional typed-in answer
    typedef struct packed {
        t_req_beat req;
        logic      has_exp;
        t_rsp_beat exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = REQ_LOOKUP;
    logic [31:0] i_key = '0;
    logic        i_key_empty = 1'b0;
    logic        i_fill_ok = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_hit;
    logic [3:0]  o_slot_index;
    logic        o_request_issued;
    logic        o_evicted;
    logic        o_fill_stored;

    lru_tag_cache_with_pending_set u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_key(i_key), .i_key_empty(i_key_empty),
        .i_fill_ok(i_fill_ok), .o_valid(o_valid), .i_stall(i_stall),
        .o_hit(o_hit), .o_slot_index(o_slot_index),
        .o_request_issued(o_request_issued), .o_evicted(o_evicted),
        .o_fill_stored(o_fill_stored)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cache shadow state
    logic [31:0] shadow_stamp [NSLOT];
    logic [31:0] shadow_tag   [NSLOT];
    logic [31:0] shadow_clock;
    logic [31:0] pend_keys    [$];

    t_rsp_beat rsp_queue [$];
    int        err_count  = 0;
    int        idle_count = 0;
    bit        long_hold  = 1'b0;

    function automatic t_rsp_beat cache_update(t_req_beat r);
        t_rsp_beat o;
        int v;
        bit found;
        o = '0;
        found = 1'b0;
        v = 0;
        case (r.req_type)
            REQ_LOOKUP: begin
                if (!r.key_empty) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!found && shadow_stamp[i] != 0 && shadow_tag[i] == r.key) begin
                            found = 1'b1;
                            shadow_clock = shadow_clock + 1;
                            shadow_stamp[i] = shadow_clock;
                            o.hit = 1'b1;
                            o.slot_index = i[3:0];
                        end
                    end
                    if (!found) begin
                        foreach (pend_keys[j]) if (pend_keys[j] == r.key) found = 1'b1;
                        if (!found) begin
                            if (pend_keys.size() < NSLOT) pend_keys.push_back(r.key);
                            o.request_issued = 1'b1;
                        end
                    end
                end
            end
            REQ_FILL: begin
                for (int j = 0; j < pend_keys.size(); j++) begin
                    if (pend_keys[j] == r.key) begin
                        pend_keys.delete(j);
                        break;
                    end
                end
                for (int i = 0; i < NSLOT; i++) begin
                    if (shadow_stamp[i] == 0) begin
                        v = i;
                        break;
                    end
                    if (shadow_stamp[i] < shadow_stamp[v]) v = i;
                end
                o.slot_index = v[3:0];
                o.evicted = shadow_stamp[v] != 0;
                shadow_tag[v] = r.key;
                if (r.fill_ok) begin
                    shadow_clock = shadow_clock + 1;
                    shadow_stamp[v] = shadow_clock;
                    o.fill_stored = shadow_clock != 0;
                end else begin
                    shadow_stamp[v] = '0;
                end
            end
            REQ_CLEAR: begin
                foreach (shadow_stamp[i]) shadow_stamp[i] = '0;
                pend_keys.delete();
            end
            default: ;
        endcase
        return o;
    endfunction

    // drive one request beat and record its expected response;
    // valid stays up after the beat, the next gap or the caller drops it
    task automatic send_beat(t_req_beat r, int gap);
        t_rsp_beat e;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= r.req_type;
        i_key       <= r.key;
        i_key_empty <= r.key_empty;
        i_fill_ok   <= r.fill_ok;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        e = cache_update(r);
        rsp_queue.push_back(e);
    endtask

    function automatic t_req_beat mk(logic [1:0] t, logic [31:0] k, logic ke, logic ok);
        t_req_beat r;
        r.req_type = t; r.key = k; r.key_empty = ke; r.fill_ok = ok;
        return r;
    endfunction

    // response checker
    always @(posedge i_clk) begin
        t_rsp_beat got;
        t_rsp_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_hit, o_slot_index, o_request_issued, o_evicted, o_fill_stored};
            if (rsp_queue.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected beat %h", got);
            end else begin
                e = rsp_queue.pop_front();
                if (got !== e) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"rsp mismatch: exp hit=%b idx=%0d req=%b ev=%b st=%b",
                                  " got hit=%b idx=%0d req=%b ev=%b st=%b"},
                            e.hit, e.slot_index, e.request_issued, e.evicted,
                            e.fill_stored, got.hit, got.slot_index,
                            got.request_issued, got.evicted, got.fill_stored);
                end
            end
        end
    end

    // receiver stall: random per beat, one long hold-off when asked
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall)) @(posedge i_clk);
        end
    end

    // watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    t_row dir_rows [] = '{
        '{mk(REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0), 1'b1, t_rsp_beat'(8'b0000_0100)},
        '{mk(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0), 1'b1, t_rsp_beat'(8'b0000_0100)},
        '{mk(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0), 1'b1, t_rsp_beat'(8'b0000_0000)},
        '{mk(REQ_LOOKUP, 32'h1234_5678, 1'b1, 1'b0), 1'b1, t_rsp_beat'(8'b0000_0000)},
        '{mk(REQ_FILL,   32'hFFFF_FFFF, 1'b1, 1'b1), 1'b1, t_rsp_beat'(8'b0000_0001)},
        '{mk(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0), 1'b1, t_rsp_beat'(8'b1000_0000)},
        '{mk(REQ_FILL,   32'h0000_0000, 1'b0, 1'b0), 1'b0, '0},
        '{mk(REQ_FILL,   32'hAAAA_5555, 1'b0, 1'b1), 1'b0, '0},
        '{mk(REQ_LOOKUP, 32'hAAAA_5555, 1'b0, 1'b0), 1'b0, '0},
        '{mk(REQ_NONE,   32'h5555_AAAA, 1'b1, 1'b1), 1'b1, t_rsp_beat'(8'b0000_0000)},
        '{mk(REQ_CLEAR,  32'h0000_0001, 1'b1, 1'b0), 1'b1, t_rsp_beat'(8'b0000_0000)},
        '{mk(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0), 1'b1, t_rsp_beat'(8'b0000_0100)}
    };

    initial begin
        t_req_beat r;
        int  pick;
        logic [31:0] pool [24];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (shadow_stamp[i]) shadow_stamp[i] = '0;
        foreach (shadow_tag[i])   shadow_tag[i] = '0;
        shadow_clock = '0;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[n]) begin
            send_beat(dir_rows[n].req, $urandom_range(0, 2));
            if (dir_rows[n].has_exp && rsp_queue[$] !== dir_rows[n].exp) begin
                err_count++;
                if (err_count <= 10)
                    $display("row %0d: table %h, predictor %h",
                        n, dir_rows[n].exp, rsp_queue[$]);
            end
        end

        // fill all slots, evicting beyond 16, distinct extremes of key bits
        for (int n = 0; n < 20; n++)
            send_beat(mk(REQ_FILL, (n[0] ? 32'hFFFF_FFF0 : 32'h0) | n, 1'b0, 1'b1), 0);
        // overflow the pending set: 20 distinct misses
        for (int n = 0; n < 20; n++)
            send_beat(mk(REQ_LOOKUP, 32'h8000_0000 + n, 1'b0, 1'b0), 0);
        // flood while the receiver holds off
        long_hold = 1'b1;
        for (int n = 0; n < 6; n++)
            send_beat(mk(REQ_LOOKUP, $urandom, 1'b0, 1'b0), 0);
        // sender pause until drained
        i_valid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);

        // random traffic: mostly lookups and fills over a small pool
        foreach (pool[i]) pool[i] = $urandom;
        for (int n = 0; n < NRAND; n++) begin
            pick = $urandom_range(0, 99);
            r = mk(REQ_LOOKUP, pool[$urandom_range(0, 23)], 1'b0, 1'b0);
            if (pick < 45) begin
                r.key_empty = ($urandom_range(0, 19) == 0);
            end else if (pick < 85) begin
                r.req_type = REQ_FILL;
                r.key_empty = 1'($urandom_range(0, 1));
                r.fill_ok = ($urandom_range(0, 4) != 0);
            end else if (pick < 92) begin
                r.key = $urandom;
                r.key_empty = 1'($urandom_range(0, 1));
            end else if (pick < 96) begin
                r.req_type = REQ_NONE;
                r.key = $urandom;
                r.fill_ok = 1'($urandom_range(0, 1));
            end else begin
                r.req_type = REQ_CLEAR;
                r.key = $urandom;
            end
            if ($urandom_range(0, 199) == 0) pool[$urandom_range(0, 23)] = $urandom;
            send_beat(r, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
        end

        i_valid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && rsp_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== lru_tag_cache_with_pending_set.f =====
hw/rtl/ltc_pkg.sv
hw/rtl/ltc_ctrl.sv
hw/rtl/ltc_dp.sv
hw/rtl/lru_tag_cache_with_pending_set.sv
test/lru_tag_cache_with_pending_set_tb.sv
